@@ sv/bpe_pkg.sv @@
// Shared types, constants and the binomial table for the Bezier patch evaluator.
// No dependencies; bpe_ram and bezier_patch_evaluator in this folder import it.
`default_nettype none

package bpe_pkg;

   localparam int MAX_ROWS_DEFAULT = 4;
   localparam int MAX_COLS_DEFAULT = 4;

   localparam int COORD_W     = 24;
   localparam int PARAM_W     = 17;
   localparam int CFG_W       = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int WGT_W       = 18;
   localparam int MUL_W       = COORD_W + 1;
   localparam int PROD_W      = 2 * MUL_W;

   localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);
   localparam logic [CFG_W-1:0]   CFG_COUNT_RESET = CFG_W'(4);

   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS_IN_USE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_COLS_IN_USE = CSR_INDEX_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POWER,
      ST_BASIS,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH
   } bpe_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_PU,
      OP_QU,
      OP_PV,
      OP_QV,
      OP_PWU,
      OP_PWV,
      OP_BU,
      OP_BV,
      OP_W,
      OP_MX,
      OP_MY,
      OP_MZ
   } bpe_op_type;

   localparam logic [5:0] BINOM_TABLE [8][8] = '{
      '{6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd2,  6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd3,  6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd4,  6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
      '{6'd1, 6'd5,  6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
      '{6'd1, 6'd6,  6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
      '{6'd1, 6'd7,  6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
   };

   function automatic logic [5:0] binom(input logic [2:0] n, input logic [2:0] i);
      return BINOM_TABLE[n][i];
   endfunction

endpackage

`default_nettype wire

@@ sv/bpe_req_if.sv @@
// Request channel of the Bezier patch evaluator: valid/ready and one load or evaluate beat.
// Depends on nothing.
`default_nettype none

interface bpe_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic [1:0]         point_row;
   logic [1:0]         point_col;
   logic signed [23:0] coord_x;
   logic signed [23:0] coord_y;
   logic signed [23:0] coord_z;
   logic [16:0]        param_u;
   logic [16:0]        param_v;

   modport source (
      output valid, action, point_row, point_col, coord_x, coord_y, coord_z,
             param_u, param_v,
      input  ready
   );

   modport sink (
      input  valid, action, point_row, point_col, coord_x, coord_y, coord_z,
             param_u, param_v,
      output ready
   );
endinterface

`default_nettype wire

@@ sv/bpe_rsp_if.sv @@
// Response channel of the Bezier patch evaluator: valid/ready and one surface point beat.
// Depends on nothing.
`default_nettype none

interface bpe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] surf_x;
   logic signed [23:0] surf_y;
   logic signed [23:0] surf_z;
   logic               clipped;

   modport source (
      output valid, surf_x, surf_y, surf_z, clipped,
      input  ready
   );

   modport sink (
      input  valid, surf_x, surf_y, surf_z, clipped,
      output ready
   );
endinterface

`default_nettype wire

@@ sv/bpe_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Depends on bpe_pkg for its default sizes.
`default_nettype none

module bpe_ram
   import bpe_pkg::*;
#(
   parameter int WIDTH = 3 * COORD_W,
   parameter int DEPTH = MAX_ROWS_DEFAULT * MAX_COLS_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/bezier_patch_evaluator.sv @@
// Bezier patch evaluator: a load beat is taken in the idle state, with the request side
// staying ready for further beats; an evaluate beat keeps the request side busy until its
// result is loaded into the response register, one evaluate at a time.
// All products share the single 25x25 multiplier, one product per cycle in multiply steps.
// Synchronous active-high reset clears the sequencer, the response valid and both counts
// (to 4); the control point RAM is not cleared and must be loaded before use.
`default_nettype none

module bezier_patch_evaluator
   import bpe_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEFAULT,
   parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bpe_req_if.sink                     req_bus,
   bpe_rsp_if.source                   rsp_bus,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_wdata
);

   localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int NPTS    = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = (NPTS > 1) ? $clog2(NPTS) : 1;
   localparam int ACC_W   = COORD_W + WGT_W + ADDR_W + 1;
   localparam int RAM_W   = 3 * COORD_W;

   bpe_state_type state_ff, state_in;
   bpe_op_type    op_ff, op_in;
   logic [2:0]       step_ff, step_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] c_ff, c_in;
   logic [IDX_W-1:0] wb_idx_ff;

   logic [CFG_W-1:0] rows_cfg_ff, cols_cfg_ff;
   logic [IDX_W-1:0] row_last, col_last;

   logic [PARAM_W-1:0] u_ff, v_ff, omu, omv;
   logic [PARAM_W-1:0] pu_ff [MAX_DIM];
   logic [PARAM_W-1:0] qu_ff [MAX_DIM];
   logic [PARAM_W-1:0] pv_ff [MAX_DIM];
   logic [PARAM_W-1:0] qv_ff [MAX_DIM];
   logic [WGT_W-1:0]   bu_ff [MAX_DIM];
   logic [WGT_W-1:0]   bv_ff [MAX_DIM];
   logic [PARAM_W-1:0] pw_ff;
   logic [WGT_W-1:0]   w_ff;
   logic [IDX_W-1:0]   p_idx, qu_idx, qv_idx;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff, rnd;
   logic signed [ACC_W-1:0]  acc_ff [3];

   logic              req_ready, accept, eval_accept, rsp_load;
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [RAM_W-1:0]  ram_wr_data, ram_rd_data;

   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] surf_ff [3];
   logic signed [COORD_W-1:0] surf_in [3];
   logic                      clipped_ff, clipped_in;

   assign accept      = req_bus.valid && req_ready;
   assign eval_accept = accept && req_bus.action;

   // count registers: zero acts as one, above the store size acts as the store size
   always_comb begin
      if (rows_cfg_ff == '0) begin
         row_last = '0;
      end else if (int'(rows_cfg_ff) > MAX_ROWS) begin
         row_last = IDX_W'(MAX_ROWS - 1);
      end else begin
         row_last = IDX_W'(rows_cfg_ff - 1'b1);
      end
      if (cols_cfg_ff == '0) begin
         col_last = '0;
      end else if (int'(cols_cfg_ff) > MAX_COLS) begin
         col_last = IDX_W'(MAX_COLS - 1);
      end else begin
         col_last = IDX_W'(cols_cfg_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= CFG_COUNT_RESET;
         cols_cfg_ff <= CFG_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE: rows_cfg_ff <= csr_wdata;
            CSR_COLS_IN_USE: cols_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control point store
   assign ram_wr_en   = accept && !req_bus.action &&
                        (int'(req_bus.point_row) < MAX_ROWS) &&
                        (int'(req_bus.point_col) < MAX_COLS);
   assign ram_wr_addr = ADDR_W'(int'(req_bus.point_row) * MAX_COLS + int'(req_bus.point_col));
   assign ram_wr_data = {req_bus.coord_z, req_bus.coord_y, req_bus.coord_x};
   assign ram_rd_addr = ADDR_W'(int'(k_ff) * MAX_COLS + int'(c_ff));

   bpe_ram #(
      .WIDTH (RAM_W),
      .DEPTH (NPTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign omu = ONE_Q16 - u_ff;
   assign omv = ONE_Q16 - v_ff;

   always_comb begin
      if (state_ff == ST_POWER) begin
         p_idx  = IDX_W'(k_ff - 1'b1);
         qu_idx = IDX_W'(k_ff - 1'b1);
         qv_idx = IDX_W'(k_ff - 1'b1);
      end else begin
         p_idx  = k_ff;
         qu_idx = (k_ff <= row_last) ? IDX_W'(row_last - k_ff) : '0;
         qv_idx = (k_ff <= col_last) ? IDX_W'(col_last - k_ff) : '0;
      end
   end

   // sequencer: next state, multiplier operands and the operation tag for write-back
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      k_in      = k_ff;
      c_in      = c_ff;
      op_in     = OP_NONE;
      mul_a     = '0;
      mul_b     = '0;
      ram_rd_en = 1'b0;
      req_ready = 1'b0;
      rsp_load  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_bus.valid && req_bus.action) begin
               step_in  = '0;
               c_in     = '0;
               state_in = (MAX_DIM > 1) ? ST_POWER : ST_BASIS;
               k_in     = (MAX_DIM > 1) ? IDX_W'(1) : '0;
            end
         end

         ST_POWER: begin
            unique case (step_ff)
               3'd0: begin
                  op_in = OP_PU;
                  mul_a = MUL_W'($signed({1'b0, pu_ff[p_idx]}));
                  mul_b = MUL_W'($signed({1'b0, u_ff}));
               end
               3'd1: begin
                  op_in = OP_QU;
                  mul_a = MUL_W'($signed({1'b0, qu_ff[qu_idx]}));
                  mul_b = MUL_W'($signed({1'b0, omu}));
               end
               3'd2: begin
                  op_in = OP_PV;
                  mul_a = MUL_W'($signed({1'b0, pv_ff[p_idx]}));
                  mul_b = MUL_W'($signed({1'b0, v_ff}));
               end
               3'd3: begin
                  op_in = OP_QV;
                  mul_a = MUL_W'($signed({1'b0, qv_ff[qv_idx]}));
                  mul_b = MUL_W'($signed({1'b0, omv}));
               end
               default: ;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               step_in = '0;
               if (int'(k_ff) == MAX_DIM - 1) begin
                  k_in     = '0;
                  state_in = ST_BASIS;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end

         ST_BASIS: begin
            unique case (step_ff)
               3'd0: begin
                  op_in = OP_PWU;
                  mul_a = MUL_W'($signed({1'b0, pu_ff[p_idx]}));
                  mul_b = MUL_W'($signed({1'b0, qu_ff[qu_idx]}));
               end
               3'd1: begin
                  op_in = OP_PWV;
                  mul_a = MUL_W'($signed({1'b0, pv_ff[p_idx]}));
                  mul_b = MUL_W'($signed({1'b0, qv_ff[qv_idx]}));
               end
               3'd2: begin
                  op_in = OP_BU;
                  mul_a = MUL_W'($signed({1'b0, pw_ff}));
                  mul_b = MUL_W'($signed({1'b0, binom(3'(row_last), 3'(k_ff))}));
               end
               3'd3: begin
                  op_in = OP_BV;
                  mul_a = MUL_W'($signed({1'b0, pw_ff}));
                  mul_b = MUL_W'($signed({1'b0, binom(3'(col_last), 3'(k_ff))}));
               end
               default: ;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               step_in = '0;
               if (int'(k_ff) == MAX_DIM - 1) begin
                  k_in     = '0;
                  c_in     = '0;
                  state_in = ST_MAC;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end

         ST_MAC: begin
            unique case (step_ff)
               3'd0: begin
                  op_in     = OP_W;
                  mul_a     = MUL_W'($signed({1'b0, bu_ff[k_ff]}));
                  mul_b     = MUL_W'($signed({1'b0, bv_ff[c_ff]}));
                  ram_rd_en = 1'b1;
               end
               3'd1: ;
               3'd2: begin
                  op_in = OP_MX;
                  mul_a = MUL_W'($signed(ram_rd_data[0 +: COORD_W]));
                  mul_b = MUL_W'($signed({1'b0, w_ff}));
               end
               3'd3: begin
                  op_in = OP_MY;
                  mul_a = MUL_W'($signed(ram_rd_data[COORD_W +: COORD_W]));
                  mul_b = MUL_W'($signed({1'b0, w_ff}));
               end
               3'd4: begin
                  op_in = OP_MZ;
                  mul_a = MUL_W'($signed(ram_rd_data[2*COORD_W +: COORD_W]));
                  mul_b = MUL_W'($signed({1'b0, w_ff}));
               end
               default: ;
            endcase
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               step_in = '0;
               if (c_ff == col_last) begin
                  c_in = '0;
                  if (k_ff == row_last) begin
                     state_in = ST_DRAIN;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end
         end

         ST_DRAIN: begin
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_NONE;
         step_ff  <= '0;
         k_ff     <= '0;
         c_ff     <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         step_ff  <= step_in;
         k_ff     <= k_in;
         c_ff     <= c_in;
      end
   end

   // shared multiplier, registered product
   always_ff @(posedge clock) begin
      prod_ff   <= mul_a * mul_b;
      wb_idx_ff <= k_ff;
   end

   assign rnd = (prod_ff + PROD_W'(32768)) >>> 16;

   // write-back of the previous cycle's product; an evaluate beat also loads u, v and clears acc
   always_ff @(posedge clock) begin
      if (eval_accept) begin
         u_ff     <= (req_bus.param_u > ONE_Q16) ? ONE_Q16 : req_bus.param_u;
         v_ff     <= (req_bus.param_v > ONE_Q16) ? ONE_Q16 : req_bus.param_v;
         pu_ff[0] <= ONE_Q16;
         qu_ff[0] <= ONE_Q16;
         pv_ff[0] <= ONE_Q16;
         qv_ff[0] <= ONE_Q16;
         for (int j = 0; j < 3; j++) begin
            acc_ff[j] <= '0;
         end
      end
      unique case (op_ff)
         OP_PU:   pu_ff[wb_idx_ff] <= rnd[PARAM_W-1:0];
         OP_QU:   qu_ff[wb_idx_ff] <= rnd[PARAM_W-1:0];
         OP_PV:   pv_ff[wb_idx_ff] <= rnd[PARAM_W-1:0];
         OP_QV:   qv_ff[wb_idx_ff] <= rnd[PARAM_W-1:0];
         OP_PWU,
         OP_PWV:  pw_ff <= rnd[PARAM_W-1:0];
         OP_BU:   bu_ff[wb_idx_ff] <= prod_ff[WGT_W-1:0];
         OP_BV:   bv_ff[wb_idx_ff] <= prod_ff[WGT_W-1:0];
         OP_W:    w_ff <= rnd[WGT_W-1:0];
         OP_MX:   acc_ff[0] <= acc_ff[0] + ACC_W'(prod_ff);
         OP_MY:   acc_ff[1] <= acc_ff[1] + ACC_W'(prod_ff);
         OP_MZ:   acc_ff[2] <= acc_ff[2] + ACC_W'(prod_ff);
         OP_NONE: ;
         default: ;
      endcase
   end

   // round to Q7.16 and saturate
   always_comb begin
      logic signed [ACC_W-1:0] q;
      clipped_in = 1'b0;
      for (int j = 0; j < 3; j++) begin
         q = (acc_ff[j] + ACC_W'(32768)) >>> 16;
         if (q > ACC_W'(COORD_MAX)) begin
            surf_in[j] = COORD_MAX;
            clipped_in = 1'b1;
         end else if (q < ACC_W'(COORD_MIN)) begin
            surf_in[j] = COORD_MIN;
            clipped_in = 1'b1;
         end else begin
            surf_in[j] = q[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         surf_ff    <= surf_in;
         clipped_ff <= clipped_in;
      end
   end

   assign req_bus.ready   = req_ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.surf_x  = surf_ff[0];
   assign rsp_bus.surf_y  = surf_ff[1];
   assign rsp_bus.surf_z  = surf_ff[2];
   assign rsp_bus.clipped = clipped_ff;

   a_eval_blocks_req : assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && req_bus.action |=> !req_bus.ready)
      else $error("request taken while an evaluate is in flight");

   a_load_no_beat : assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && !req_bus.action && !rsp_bus.valid
      |=> !rsp_bus.valid)
      else $error("load produced a response beat");

   a_idle_no_writeback : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE || state_ff == ST_FINISH |-> op_ff == OP_NONE)
      else $error("multiplier write-back outside an evaluate");

   a_clip_at_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.clipped |->
         rsp_bus.surf_x == COORD_MAX || rsp_bus.surf_x == COORD_MIN ||
         rsp_bus.surf_y == COORD_MAX || rsp_bus.surf_y == COORD_MIN ||
         rsp_bus.surf_z == COORD_MAX || rsp_bus.surf_z == COORD_MIN)
      else $error("clipped set with no coordinate at a limit");

endmodule

`default_nettype wire

@@ verif/bezier_patch_evaluator_tb.sv @@
// Testbench for the Bezier patch evaluator: loads control points, evaluates surface points
// and checks every response beat against a fixed-point surface predictor or a known answer.
// Depends on bpe_pkg, bpe_req_if, bpe_rsp_if and bezier_patch_evaluator.
`timescale 1ns / 1ps

module bezier_patch_evaluator_tb;
   import bpe_pkg::*;

   localparam int MAX_ROWS       = MAX_ROWS_DEFAULT;
   localparam int MAX_COLS       = MAX_COLS_DEFAULT;
   localparam int RANDOM_BEATS   = 950;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EVAL = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = CSR_INDEX_W'(3);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [PARAM_W-1:0]        param_type;

   typedef struct packed {
      logic       action;
      logic [1:0] point_row;
      logic [1:0] point_col;
      coord_type  coord_x;
      coord_type  coord_y;
      coord_type  coord_z;
      param_type  param_u;
      param_type  param_v;
   } req_beat_type;

   typedef struct packed {
      coord_type surf_x;
      coord_type surf_y;
      coord_type surf_z;
      logic      clipped;
   } surf_point_type;

   typedef enum logic {STEP_CONFIG, STEP_BEAT} step_kind_type;

   typedef struct {
      step_kind_type    kind;
      logic [CFG_W-1:0] rows;
      logic [CFG_W-1:0] cols;
      req_beat_type     beat;
      bit               has_answer;
      surf_point_type   answer;
   } plan_step_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CFG_W-1:0]       csr_wdata;

   bpe_req_if req_if ();
   bpe_rsp_if rsp_if ();

   bezier_patch_evaluator dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   coord_type        patch_x [MAX_ROWS][MAX_COLS];
   coord_type        patch_y [MAX_ROWS][MAX_COLS];
   coord_type        patch_z [MAX_ROWS][MAX_COLS];
   logic [CFG_W-1:0] rows_reg = CFG_COUNT_RESET;
   logic [CFG_W-1:0] cols_reg = CFG_COUNT_RESET;
   surf_point_type   pending_points [$];
   plan_step_type    directed_plan [$];
   surf_point_type   no_answer = '0;
   int unsigned      mismatches = 0;
   int unsigned      beats_sent = 0;
   int unsigned      burst_left = 0;

   function automatic int unsigned active_count(input logic [CFG_W-1:0] v,
                                                input int unsigned limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic longint unsigned round_mul(input longint unsigned a, b);
      return (a * b + 64'd32768) >> 16;
   endfunction

   function automatic longint unsigned q16_power(input longint unsigned base,
                                                 input int unsigned e);
      longint unsigned p;
      p = longint'(ONE_Q16);
      repeat (e) p = round_mul(p, base);
      return p;
   endfunction

   function automatic longint unsigned binomial(input int unsigned n, k);
      longint unsigned c;
      c = 1;
      for (int unsigned j = 0; j < k; j++) c = c * (n - j) / (j + 1);
      return c;
   endfunction

   function automatic longint unsigned bernstein(input int unsigned i, n,
                                                 input longint unsigned t);
      return round_mul(q16_power(t, i), q16_power(longint'(ONE_Q16) - t, n - i))
             * binomial(n, i);
   endfunction

   function automatic surf_point_type surface_point(input param_type u_in, v_in);
      int unsigned     nr;
      int unsigned     nc;
      longint unsigned u;
      longint unsigned v;
      longint unsigned bu [MAX_ROWS];
      longint unsigned bv [MAX_COLS];
      longint          acc [3];
      longint          w;
      longint          q;
      coord_type       sat [3];
      surf_point_type  p;
      nr = active_count(rows_reg, MAX_ROWS);
      nc = active_count(cols_reg, MAX_COLS);
      u  = (u_in > ONE_Q16) ? longint'(ONE_Q16) : longint'(u_in);
      v  = (v_in > ONE_Q16) ? longint'(ONE_Q16) : longint'(v_in);
      for (int unsigned r = 0; r < nr; r++) bu[r] = bernstein(r, nr - 1, u);
      for (int unsigned c = 0; c < nc; c++) bv[c] = bernstein(c, nc - 1, v);
      acc = '{0, 0, 0};
      for (int unsigned r = 0; r < nr; r++) begin
         for (int unsigned c = 0; c < nc; c++) begin
            w = longint'(round_mul(bu[r], bv[c]));
            acc[0] += longint'(patch_x[r][c]) * w;
            acc[1] += longint'(patch_y[r][c]) * w;
            acc[2] += longint'(patch_z[r][c]) * w;
         end
      end
      p.clipped = 1'b0;
      for (int k = 0; k < 3; k++) begin
         q = (acc[k] + 64'sd32768) >>> 16;
         if (q > longint'(COORD_MAX)) begin
            q = longint'(COORD_MAX);
            p.clipped = 1'b1;
         end else if (q < longint'(COORD_MIN)) begin
            q = longint'(COORD_MIN);
            p.clipped = 1'b1;
         end
         sat[k] = coord_type'(q);
      end
      p.surf_x = sat[0];
      p.surf_y = sat[1];
      p.surf_z = sat[2];
      return p;
   endfunction

   function automatic req_beat_type random_beat(input logic action);
      req_beat_type b;
      b.action    = action;
      b.point_row = 2'($urandom);
      b.point_col = 2'($urandom);
      b.coord_x   = coord_type'($urandom);
      b.coord_y   = coord_type'($urandom);
      b.coord_z   = coord_type'($urandom);
      b.param_u   = param_type'($urandom);
      b.param_v   = param_type'($urandom);
      return b;
   endfunction

   function automatic param_type pick_param();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ONE_Q16;
         2: return param_type'($urandom_range(65537, 131071));
         default: return param_type'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic coord_type pick_coord(input int unsigned style, input coord_type shared);
      case (style)
         1: return coord_type'($urandom_range(0, 32'h7FFFF) - 32'h40000);
         2: return shared;
         3: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic plan_step_type config_step(input logic [CFG_W-1:0] rows, cols);
      plan_step_type s;
      s.kind       = STEP_CONFIG;
      s.rows       = rows;
      s.cols       = cols;
      s.beat       = '0;
      s.has_answer = 1'b0;
      s.answer     = '0;
      return s;
   endfunction

   function automatic plan_step_type load_step(input logic [1:0] row, col,
                                               input coord_type x, y, z);
      plan_step_type s;
      s = config_step('0, '0);
      s.kind           = STEP_BEAT;
      s.beat           = random_beat(ACT_LOAD);
      s.beat.point_row = row;
      s.beat.point_col = col;
      s.beat.coord_x   = x;
      s.beat.coord_y   = y;
      s.beat.coord_z   = z;
      return s;
   endfunction

   function automatic plan_step_type eval_step(input param_type u, v);
      plan_step_type s;
      s = config_step('0, '0);
      s.kind         = STEP_BEAT;
      s.beat         = random_beat(ACT_EVAL);
      s.beat.param_u = u;
      s.beat.param_v = v;
      return s;
   endfunction

   function automatic plan_step_type known_step(input param_type u, v,
                                                input coord_type x, y, z,
                                                input logic clip);
      plan_step_type s;
      s = eval_step(u, v);
      s.has_answer = 1'b1;
      s.answer     = '{surf_x: x, surf_y: y, surf_z: z, clipped: clip};
      return s;
   endfunction

   function automatic void add_step(input plan_step_type s);
      directed_plan = {directed_plan, s};
   endfunction

   function automatic void record_beat(input req_beat_type b, input bit has_answer,
                                       input surf_point_type answer);
      if (b.action == ACT_LOAD) begin
         patch_x[b.point_row][b.point_col] = b.coord_x;
         patch_y[b.point_row][b.point_col] = b.coord_y;
         patch_z[b.point_row][b.point_col] = b.coord_z;
      end else begin
         pending_points = {pending_points,
                           (has_answer ? answer : surface_point(b.param_u, b.param_v))};
      end
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want, got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_beat(input req_beat_type b, input bit has_answer,
                            input surf_point_type answer);
      @(negedge clock);
      req_if.valid     = 1'b1;
      req_if.action    = b.action;
      req_if.point_row = b.point_row;
      req_if.point_col = b.point_col;
      req_if.coord_x   = b.coord_x;
      req_if.coord_y   = b.coord_y;
      req_if.coord_z   = b.coord_z;
      req_if.param_u   = b.param_u;
      req_if.param_v   = b.param_v;
      do @(posedge clock); while (!req_if.ready);
      record_beat(b, has_answer, answer);
      beats_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat ($urandom_range(0, 9)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic csr_pulse(input logic [CSR_INDEX_W-1:0] idx, input logic [CFG_W-1:0] data);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = data;
   endtask

   task automatic write_config(input logic [CFG_W-1:0] rows, cols);
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_pulse(CSR_ROWS_IN_USE, rows);
      csr_pulse(CSR_COLS_IN_USE, cols);
      csr_pulse($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, CFG_W'($urandom));
      @(negedge clock);
      csr_write = 1'b0;
      rows_reg  = rows;
      cols_reg  = cols;
   endtask

   int unsigned ready_pct   = 100;
   int unsigned ready_epoch = 0;

   always @(negedge clock) begin
      if (ready_epoch == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 80;
            2: ready_pct = 50;
            default: ready_pct = 25;
         endcase
         ready_epoch = $urandom_range(50, 400);
      end else begin
         ready_epoch--;
      end
      rsp_if.ready = ($urandom_range(1, 100) <= ready_pct);
   end

   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      surf_point_type want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_write)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_points.size() == 0) begin
               $error("response beat with no evaluate outstanding");
               mismatches++;
            end else begin
               want = pending_points.pop_front();
               check_field("surf_x", want.surf_x, rsp_if.surf_x);
               check_field("surf_y", want.surf_y, rsp_if.surf_y);
               check_field("surf_z", want.surf_z, rsp_if.surf_z);
               check_field("clipped", want.clipped, rsp_if.clipped);
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      req_beat_type     b;
      coord_type        shared [3];
      logic [CFG_W-1:0] cfg_rows;
      logic [CFG_W-1:0] cfg_cols;
      int unsigned      nr;
      int unsigned      nc;
      int unsigned      style;
      int unsigned      phase;
      int unsigned      next_phase;
      int unsigned      random_start;

      reset            = 1'b1;
      csr_write        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.action    = ACT_LOAD;
      req_if.point_row = '0;
      req_if.point_col = '0;
      req_if.coord_x   = '0;
      req_if.coord_y   = '0;
      req_if.coord_z   = '0;
      req_if.param_u   = '0;
      req_if.param_v   = '0;
      rsp_if.ready     = 1'b0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single point: every weight collapses to one
      add_step(config_step(3'd1, 3'd1));
      add_step(load_step(2'd0, 2'd0, COORD_MAX, COORD_MIN, 24'sd0));
      add_step(known_step(17'd0, 17'd0, COORD_MAX, COORD_MIN, 24'sd0, 1'b0));
      add_step(known_step(17'h1FFFF, ONE_Q16, COORD_MAX, COORD_MIN, 24'sd0, 1'b0));
      add_step(known_step(17'd12345, 17'd54321, COORD_MAX, COORD_MIN, 24'sd0, 1'b0));
      add_step(load_step(2'd3, 2'd3, COORD_MIN, COORD_MAX, -24'sd1));
      // zero counts act as one
      add_step(config_step(3'd0, 3'd0));
      add_step(known_step(17'd40000, 17'd1, COORD_MAX, COORD_MIN, 24'sd0, 1'b0));
      add_step(known_step(17'd65535, 17'h10001, COORD_MAX, COORD_MIN, 24'sd0, 1'b0));
      // two rows: u at its ends picks one row
      add_step(config_step(3'd2, 3'd0));
      add_step(load_step(2'd1, 2'd0, 24'sd1, -24'sd1, COORD_MAX));
      add_step(known_step(17'd0, 17'd0, COORD_MAX, COORD_MIN, 24'sd0, 1'b0));
      add_step(known_step(ONE_Q16, 17'd0, 24'sd1, -24'sd1, COORD_MAX, 1'b0));
      add_step(eval_step(17'd32768, 17'd999));
      add_step(eval_step(17'd1, 17'd65535));
      // two columns: v above one saturates to the last column
      add_step(config_step(3'd0, 3'd2));
      add_step(load_step(2'd0, 2'd1, 24'sh123456, -24'sh654321, 24'sh400000));
      add_step(known_step(17'd0, ONE_Q16, 24'sh123456, -24'sh654321, 24'sh400000, 1'b0));
      add_step(known_step(17'h18000, 17'h1C000, 24'sh123456, -24'sh654321, 24'sh400000,
                          1'b0));
      add_step(eval_step(17'd20000, 17'd20000));

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_CONFIG)
            write_config(directed_plan[i].rows, directed_plan[i].cols);
         else
            send_beat(directed_plan[i].beat, directed_plan[i].has_answer,
                      directed_plan[i].answer);
      end

      random_start = beats_sent;
      for (int r = 0; r < MAX_ROWS; r++) begin
         for (int c = 0; c < MAX_COLS; c++) begin
            b = random_beat(ACT_LOAD);
            b.point_row = 2'(r);
            b.point_col = 2'(c);
            send_beat(b, 1'b0, no_answer);
         end
      end

      phase      = 0;
      next_phase = beats_sent;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         if (beats_sent >= next_phase) begin
            case (phase)
               0: begin cfg_rows = 3'd4; cfg_cols = 3'd4; end
               1: begin cfg_rows = 3'd7; cfg_cols = 3'd5; end
               2: begin cfg_rows = 3'd1; cfg_cols = 3'd4; end
               3: begin cfg_rows = 3'd4; cfg_cols = 3'd1; end
               4: begin cfg_rows = 3'd0; cfg_cols = 3'd7; end
               5: begin cfg_rows = 3'd3; cfg_cols = 3'd2; end
               default: begin
                  cfg_rows = CFG_W'($urandom);
                  cfg_cols = CFG_W'($urandom);
               end
            endcase
            write_config(cfg_rows, cfg_cols);
            phase++;
            next_phase = beats_sent + $urandom_range(50, 100);
         end
         nr = active_count(rows_reg, MAX_ROWS);
         nc = active_count(cols_reg, MAX_COLS);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               style = $urandom_range(0, 3);
               for (int k = 0; k < 3; k++)
                  shared[k] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
               for (int r = 0; r < nr; r++) begin
                  for (int c = 0; c < nc; c++) begin
                     b = random_beat(ACT_LOAD);
                     b.point_row = 2'(r);
                     b.point_col = 2'(c);
                     b.coord_x   = pick_coord(style, shared[0]);
                     b.coord_y   = pick_coord(style, shared[1]);
                     b.coord_z   = pick_coord(style, shared[2]);
                     send_beat(b, 1'b0, no_answer);
                  end
               end
               repeat ($urandom_range(1, 5)) begin
                  b = random_beat(ACT_EVAL);
                  b.param_u = pick_param();
                  b.param_v = pick_param();
                  send_beat(b, 1'b0, no_answer);
               end
            end
            4, 5, 6, 7: begin
               repeat ($urandom_range(1, 6)) begin
                  b = random_beat(ACT_EVAL);
                  b.param_u = pick_param();
                  b.param_v = pick_param();
                  send_beat(b, 1'b0, no_answer);
               end
            end
            default: begin
               repeat ($urandom_range(1, 3)) send_beat(random_beat(ACT_LOAD), 1'b0, no_answer);
            end
         endcase
      end

      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ bezier_patch_evaluator.f @@
sv/bpe_pkg.sv
sv/bpe_req_if.sv
sv/bpe_rsp_if.sv
sv/bpe_ram.sv
sv/bezier_patch_evaluator.sv
verif/bezier_patch_evaluator_tb.sv
